// File: hdl/itew_pkg.sv
// itew_pkg: widths, token codes and shared types for the integer-to-words unit.
// No dependencies; imported by every module under hdl.
package itew_pkg;

  localparam int NUM_W     = 31;            // input integer width
  localparam int DIGITS    = 10;            // decimal digits of the largest input
  localparam int BCD_W     = 4 * DIGITS;    // packed BCD width
  localparam int GRP_DIGITS = 12;           // four groups of three digits
  localparam int GRP_W     = 4 * GRP_DIGITS;
  localparam int TOK_W     = 5;
  localparam int CNT_W     = $clog2(NUM_W + 1);

  localparam logic [TOK_W-1:0] TOK_ZERO     = 5'd0;
  localparam logic [TOK_W-1:0] TOK_TEN      = 5'd10;
  localparam logic [TOK_W-1:0] TOK_TENS0    = 5'd20;
  localparam logic [TOK_W-1:0] TOK_HUNDRED  = 5'd28;
  localparam logic [TOK_W-1:0] TOK_THOUSAND = 5'd29;
  localparam logic [TOK_W-1:0] TOK_MILLION  = 5'd30;
  localparam logic [TOK_W-1:0] TOK_BILLION  = 5'd31;

  typedef logic [3:0] digit_t;

  // converter to sequencer: finished BCD value and its strobe
  typedef struct packed {
    logic             done;
    logic [BCD_W-1:0] bcd;
  } bcd_result_t;

  // double-dabble correction: every digit of five or more gets three added
  function automatic logic [BCD_W-1:0] bcd_adjust(input logic [BCD_W-1:0] v);
    logic [BCD_W-1:0] r;
    digit_t d;
    r = v;
    for (int i = 0; i < DIGITS; i++) begin
      d = v[4*i +: 4];
      if (d >= 4'd5) r[4*i +: 4] = d + 4'd3;
    end
    return r;
  endfunction

endpackage

// File: hdl/itew_bin2bcd.sv
// itew_bin2bcd: bit-serial binary to BCD conversion (shift and add three).
// Depends on itew_pkg.
module itew_bin2bcd
  import itew_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [NUM_W-1:0] number,
  output logic             busy,
  output bcd_result_t      result
);

  logic [NUM_W-1:0] bin;
  logic [BCD_W-1:0] bcd;
  logic [BCD_W-1:0] bcd_adj;
  logic [CNT_W-1:0] cnt;
  logic             done;

  assign bcd_adj = bcd_adjust(bcd);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= !start && busy && cnt == CNT_W'(NUM_W - 1);
      if (start) begin
        busy <= 1'b1;
      end else if (busy && cnt == CNT_W'(NUM_W - 1)) begin
        busy <= 1'b0;
      end
    end
  end

  // one input bit enters the BCD register per cycle, MSB first
  always_ff @(posedge clk) begin
    if (start) begin
      bin <= number;
      bcd <= '0;
      cnt <= '0;
    end else if (busy) begin
      bcd <= {bcd_adj[BCD_W-2:0], bin[NUM_W-1]};
      bin <= {bin[NUM_W-2:0], 1'b0};
      cnt <= cnt + CNT_W'(1);
    end
  end

  assign result.done = done;
  assign result.bcd  = bcd;

  a_start_idle: assert property (@(posedge clk) disable iff (rst) start |-> !busy)
    else $error("conversion started while busy");
  a_done_ends: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("done raised while still converting");

endmodule

// File: hdl/itew_token_seq.sv
// itew_token_seq: walks the BCD groups from billions down and issues word tokens.
// Depends on itew_pkg; output held in a single register towards the master side.
module itew_token_seq
  import itew_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  bcd_result_t      conv,
  output logic             idle,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [TOK_W-1:0] out_word,
  output logic             out_last
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_GROUP = 3'd1;
  localparam logic [2:0] S_HWORD = 3'd2;
  localparam logic [2:0] S_TENS  = 3'd3;
  localparam logic [2:0] S_UNIT  = 3'd4;
  localparam logic [2:0] S_SCALE = 3'd5;

  logic [2:0]       state, state_next;
  logic [GRP_W-1:0] digits;
  logic [1:0]       grp;
  logic             can_step, emit, emit_last, shift_grp;
  logic [TOK_W-1:0] emit_word;
  digit_t           h, t, u;
  logic             rest_nz, grp_nz, has_scale, tail;

  assign h         = digits[GRP_W-1 -: 4];
  assign t         = digits[GRP_W-5 -: 4];
  assign u         = digits[GRP_W-9 -: 4];
  assign rest_nz   = |digits[GRP_W-13:0];
  assign grp_nz    = |digits[GRP_W-1 -: 12];
  assign has_scale = grp != 2'd3;
  // something follows this group's last digit word
  assign tail      = has_scale || rest_nz;
  assign can_step  = !out_valid || out_ready;
  assign idle      = state == S_IDLE;

  always_comb begin
    state_next = state;
    emit       = 1'b0;
    emit_word  = TOK_ZERO;
    emit_last  = 1'b0;
    shift_grp  = 1'b0;
    case (state)
      S_IDLE: begin
        if (conv.done) state_next = S_GROUP;
      end
      S_GROUP: begin
        if (!grp_nz && !rest_nz) begin
          // whole value is zero
          emit       = 1'b1;
          emit_last  = 1'b1;
          state_next = S_IDLE;
        end else if (!grp_nz) begin
          shift_grp = 1'b1;
        end else if (h != 4'd0) begin
          emit       = 1'b1;
          emit_word  = {1'b0, h};
          state_next = S_HWORD;
        end else begin
          state_next = S_TENS;
        end
      end
      S_HWORD: begin
        emit       = 1'b1;
        emit_word  = TOK_HUNDRED;
        emit_last  = t == 4'd0 && u == 4'd0 && !tail;
        state_next = S_TENS;
      end
      S_TENS: begin
        if (t == 4'd1) begin
          emit       = 1'b1;
          emit_word  = TOK_TEN + TOK_W'(u);
          emit_last  = !tail;
          state_next = S_SCALE;
        end else if (t != 4'd0) begin
          emit       = 1'b1;
          emit_word  = TOK_TENS0 + TOK_W'(t) - TOK_W'(2);
          emit_last  = u == 4'd0 && !tail;
          state_next = S_UNIT;
        end else begin
          state_next = S_UNIT;
        end
      end
      S_UNIT: begin
        if (u != 4'd0) begin
          emit      = 1'b1;
          emit_word = {1'b0, u};
          emit_last = !tail;
        end
        state_next = S_SCALE;
      end
      S_SCALE: begin
        if (has_scale) begin
          emit      = 1'b1;
          emit_word = TOK_BILLION - TOK_W'(grp);
          emit_last = !rest_nz;
        end
        if (rest_nz) begin
          shift_grp  = 1'b1;
          state_next = S_GROUP;
        end else begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
    // nothing is left to issue once the final word has gone
    if (emit && emit_last) state_next = S_IDLE;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      out_valid <= (out_valid && !out_ready) || (state != S_IDLE && can_step && emit);
      if (state == S_IDLE || can_step) begin
        state <= state_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE && conv.done) begin
      digits <= {{(GRP_W - BCD_W){1'b0}}, conv.bcd};
      grp    <= 2'd0;
    end else if (state != S_IDLE && can_step) begin
      if (emit) begin
        out_word <= emit_word;
        out_last <= emit_last;
      end
      if (shift_grp) begin
        digits <= {digits[GRP_W-13:0], 12'd0};
        grp    <= grp + 2'd1;
      end
    end
  end

  a_last_ends: assert property (@(posedge clk) disable iff (rst)
      state != S_IDLE && can_step && emit && emit_last |=> state == S_IDLE)
    else $error("sequencer kept running after the final word");
  a_load_idle: assert property (@(posedge clk) disable iff (rst)
      conv.done |-> state == S_IDLE)
    else $error("BCD result arrived while words were still being issued");
  a_top_clear: assert property (@(posedge clk) disable iff (rst)
      state != S_IDLE && grp == 2'd0 |-> digits[GRP_W-1 -: 8] == 8'd0)
    else $error("billions group holds more than one digit");

endmodule

// File: hdl/integer_to_english_word_tokens_unit.sv
// integer_to_english_word_tokens_unit: top level, names a 31-bit integer as word tokens.
// Depends on itew_pkg, itew_bin2bcd and itew_token_seq.
//
//  channel | dir | handshake         | payload
//  s_*     | in  | s_tvalid/s_tready | s_tdata: number
//  m_*     | out | m_tvalid/m_tready | m_tdata: word, m_tlast: last
//
// One number passes through the bit-serial BCD converter, which then hands the
// digits over; the token sequencer steps through up to five states per nonzero
// group (hundreds, Hundred, tens, unit, scale) and one per zero group, stopping
// on the final word. A new number is taken once the sequencer has issued the
// previous final word into the output register.
// Reset is synchronous on rst. A stalled m_tready holds the sequencer in place.
module integer_to_english_word_tokens_unit
  import itew_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // [30:0] number, [31] zero
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // [4:0] word, [7:5] zero
  output logic        m_tlast
);

  logic             conv_busy, seq_idle, start;
  bcd_result_t      conv;
  logic [TOK_W-1:0] word;

  assign s_tready = !conv_busy && seq_idle && !conv.done;
  assign start    = s_tvalid && s_tready;

  itew_bin2bcd u_conv (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .number (s_tdata[NUM_W-1:0]),
    .busy   (conv_busy),
    .result (conv)
  );

  itew_token_seq u_seq (
    .clk       (clk),
    .rst       (rst),
    .conv      (conv),
    .idle      (seq_idle),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_word  (word),
    .out_last  (m_tlast)
  );

  assign m_tdata = {3'd0, word};

endmodule

// File: tb/integer_to_english_word_tokens_unit_tb.sv
// Self-checking bench for integer_to_english_word_tokens_unit: numbers in, word tokens out.
// Directed table then grouped and random numbers, checked against typed runs or a token predictor.
// Depends on itew_pkg and the unit under hdl.
module integer_to_english_word_tokens_unit_tb;
  import itew_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int IDLE_LIMIT = 2000;  // cycles with no word moving on either side
  localparam int DRAIN_CYCLES = 60;
  localparam int N_RANDOM = 340;
  localparam int N_DIR = 22;
  localparam int MAX_WORDS = 16;
  localparam int MAX_SHOWN = 40;
  localparam logic [NUM_W-1:0] NUM_MAX = 31'h7FFF_FFFF;

  typedef struct packed {
    logic [TOK_W-1:0] word;
    logic             last;
  } tok_word_t;

  // typed rows: word i of the expected run sits at [TOK_W*i +: TOK_W]
  typedef struct {
    logic [NUM_W-1:0]           number;
    int                         n_typed;
    logic [MAX_WORDS*TOK_W-1:0] typed;
  } num_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata = '0;   // [30:0] number, [31] zero
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [7:0]  m_tdata;        // [4:0] word, [7:5] zero
  logic        m_tlast;

  tok_word_t word_q[$];
  int        mismatches = 0;
  int        idle_cycles = 0;
  bit        fast_phase = 1'b0;

  num_row_t dir_rows [N_DIR] = '{
    '{31'd0,          1, {75'd0, TOK_ZERO}},
    '{31'd1,          1, 80'd1},
    '{31'd19,         1, 80'd19},
    '{31'd10,         0, '0},
    '{31'd11,         0, '0},
    '{31'd20,         0, '0},
    '{31'd99,         0, '0},
    '{31'd100,        0, '0},
    '{31'd101,        0, '0},
    '{31'd115,        0, '0},
    '{31'd999,        0, '0},
    '{31'd1000,       0, '0},
    '{31'd1001,       0, '0},
    '{31'd90019,      0, '0},
    '{31'd1000000,    0, '0},
    '{31'd1000000000, 2, {70'd0, TOK_BILLION, 5'd1}},
    '{31'd1000000001, 0, '0},
    '{31'd1010101010, 0, '0},
    '{31'd2000000000, 0, '0},
    '{31'h5555_5555,  0, '0},
    '{31'h2AAA_AAAA,  0, '0},
    // largest input, sixteen words
    '{NUM_MAX, 16, {5'd7, 5'd22, TOK_HUNDRED, 5'd6, TOK_THOUSAND, 5'd3, 5'd26,
                    TOK_HUNDRED, 5'd4, TOK_MILLION, 5'd7, 5'd22, TOK_HUNDRED,
                    5'd1, TOK_BILLION, 5'd2}}
  };

  integer_to_english_word_tokens_unit u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  task automatic report_mismatch(input string msg);
    mismatches++;
    if (mismatches <= MAX_SHOWN) $display("[%0t] MISMATCH: %s", $realtime, msg);
  endtask

  function automatic void push_word(input logic [TOK_W-1:0] w);
    word_q.push_back('{w, 1'b0});
  endfunction

  // one three-digit group: hundreds, Hundred, teen or tens plus unit, scale
  function automatic void push_group(input int unsigned grp, input logic [TOK_W-1:0] scale,
                                     input bit has_scale);
    int unsigned rest;
    if (grp == 0) return;
    rest = grp % 100;
    if (grp >= 100) begin
      push_word(TOK_W'(grp / 100));
      push_word(TOK_HUNDRED);
    end
    if (rest != 0 && rest < 20) begin
      push_word(TOK_W'(rest));
    end else if (rest != 0) begin
      push_word(TOK_TENS0 + TOK_W'(rest / 10) - TOK_W'(2));
      if (rest % 10 != 0) push_word(TOK_W'(rest % 10));
    end
    if (has_scale) push_word(scale);
  endfunction

  function automatic void predict_words(input logic [NUM_W-1:0] number);
    int unsigned n;
    n = {1'b0, number};
    if (n == 0) begin
      push_word(TOK_ZERO);
    end else begin
      push_group(n / 1000000000, TOK_BILLION, 1'b1);
      push_group((n / 1000000) % 1000, TOK_MILLION, 1'b1);
      push_group((n / 1000) % 1000, TOK_THOUSAND, 1'b1);
      push_group(n % 1000, TOK_ZERO, 1'b0);
    end
    word_q[$].last = 1'b1;
  endfunction

  // mostly numbers built from groups, so that zero groups, teens and round tens all turn up
  function automatic logic [NUM_W-1:0] pick_number();
    longint total;
    int unsigned grp;
    case ($urandom_range(0, 9))
      0, 1: return NUM_W'($urandom());
      2:    return NUM_W'($urandom_range(0, 999));
      default: begin
        // billions digit, then millions, thousands and units groups shifted in below it
        total = longint'($urandom_range(0, 2));
        for (int i = 0; i < 3; i++) begin
          case ($urandom_range(0, 3))
            0: grp = 0;
            1: grp = $urandom_range(0, 19);
            2: grp = $urandom_range(1, 9) * 100 + $urandom_range(0, 9) * 10;
            default: grp = $urandom_range(0, 999);
          endcase
          total = total * 1000 + grp;
        end
        if (total > longint'(NUM_MAX)) total -= 1000000000;
        return NUM_W'(total);
      end
    endcase
  endfunction

  task automatic send_number(input logic [NUM_W-1:0] number);
    int gap;
    gap = fast_phase ? 0 : $urandom_range(0, 17);
    repeat (gap) begin
      @(negedge clk);
      s_tvalid <= 1'b0;
    end
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tdata  <= {1'b0, number};
    do @(posedge clk); while (!s_tready);
  endtask

  initial begin : stimulus
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (dir_rows[r]) begin
      send_number(dir_rows[r].number);
      if (dir_rows[r].n_typed == 0) begin
        predict_words(dir_rows[r].number);
      end else begin
        for (int i = 0; i < dir_rows[r].n_typed; i++)
          word_q.push_back('{dir_rows[r].typed[TOK_W*i +: TOK_W],
                             i == dir_rows[r].n_typed - 1});
      end
    end

    for (int k = 0; k < N_RANDOM; k++) begin
      if (k % 40 == 0) fast_phase = ($urandom_range(0, 3) == 0);
      begin
        logic [NUM_W-1:0] number;
        number = pick_number();
        send_number(number);
        predict_words(number);
      end
    end
    @(negedge clk);
    s_tvalid <= 1'b0;

    while (word_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin : word_sink
    tok_word_t want;
    int stall;
    forever begin
      stall = fast_phase ? 0 : $urandom_range(0, 17);
      repeat (stall) begin
        @(negedge clk);
        m_tready <= 1'b0;
      end
      @(negedge clk);
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
      if (word_q.size() == 0) begin
        report_mismatch($sformatf("unexpected word %0d last %0b", m_tdata[TOK_W-1:0], m_tlast));
      end else begin
        want = word_q.pop_front();
        if (m_tdata[TOK_W-1:0] !== want.word)
          report_mismatch($sformatf("word %0d, wanted %0d", m_tdata[TOK_W-1:0], want.word));
        if (m_tlast !== want.last)
          report_mismatch($sformatf("last %0b on word %0d, wanted %0b",
                                    m_tlast, want.word, want.last));
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : watchdog
    while (idle_cycles < IDLE_LIMIT) @(posedge clk);
    $display("Some tests failed");
    $finish;
  end

endmodule
